// File: rtl/ctl_pkg.sv
// ----------------------------------------------------------------------------
// ctl_pkg
// Types, constants and helper functions shared by the C token lexer.
// ----------------------------------------------------------------------------
package ctl_pkg;

  localparam int TextBytes    = 8;
  localparam int KeywordCount = 34;
  localparam logic [15:0] TokenLimitReset = 16'd200;
  localparam logic [7:0]  LengthMax       = 8'd255;

  typedef enum logic [2:0] {
    ClassKeyword    = 3'd0,
    ClassNumber     = 3'd1,
    ClassIdentifier = 3'd2,
    ClassOperator   = 3'd3,
    ClassDelimiter  = 3'd4,
    ClassOther      = 3'd5
  } tclass_t;

  typedef struct packed {
    logic       action;
    logic [7:0] character;
  } char_t;

  typedef struct packed {
    tclass_t     token_class;
    logic [7:0]  token_start;
    logic [7:0]  token_length;
    logic [63:0] token_text;
    logic [15:0] token_number;
    logic        last_of_run;
  } tok_t;

  typedef struct packed {
    logic [1:0] n;
    tok_t       a;
    tok_t       b;
  } push_t;

  localparam logic [63:0] KeywordLit [KeywordCount] = '{
    64'("int"), 64'("float"), 64'("double"), 64'("char"), 64'("void"),
    64'("for"), 64'("while"), 64'("do"), 64'("if"), 64'("else"),
    64'("typedef"), 64'("enum"), 64'("struct"), 64'("return"), 64'("const"),
    64'("sizeof"), 64'("inline"), 64'("static"), 64'("extern"), 64'("long"),
    64'("default"), 64'("short"), 64'("register"), 64'("restrict"),
    64'("signed"), 64'("unsigned"), 64'("union"), 64'("switch"),
    64'("continue"), 64'("goto"), 64'("case"), 64'("break"),
    64'("volatile"), 64'("auto")
  };

  // string literal has its first byte highest; turn it to first byte lowest
  function automatic logic [63:0] first_byte_low(logic [63:0] s);
    int          n;
    logic [63:0] r;
    n = 0;
    r = '0;
    for (int i = 0; i < TextBytes; i++) begin
      if (s[8*i +: 8] != 8'd0) n = i + 1;
    end
    for (int i = 0; i < TextBytes; i++) begin
      if (i < n) r[8*i +: 8] = s[8*(n-1-i) +: 8];
    end
    return r;
  endfunction

  function automatic logic keyword_hit(logic [63:0] text, logic [7:0] len);
    logic hit;
    hit = 1'b0;
    for (int k = 0; k < KeywordCount; k++) begin
      if (text == first_byte_low(KeywordLit[k])) hit = 1'b1;
    end
    return hit && (len != 8'd0) && (len <= 8'(TextBytes));
  endfunction

  function automatic tclass_t word_class(logic [63:0] text, logic [7:0] len);
    logic [7:0] f;
    f = text[7:0];
    if (keyword_hit(text, len)) return ClassKeyword;
    if (f >= "0" && f <= "9") return ClassNumber;
    if ((f >= "a" && f <= "z") || (f >= "A" && f <= "Z")) return ClassIdentifier;
    return ClassOther;
  endfunction

  function automatic tclass_t punct_class(logic [7:0] c);
    tclass_t r;
    case (c) inside
      "+", "-", "/", "=", "*", "&", "!", "%": r = ClassOperator;
      ";", "(", ")", "{", "}", "[", "]", ",", ":": r = ClassDelimiter;
      default: r = ClassOther;
    endcase
    return r;
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_punct(logic [7:0] c);
    return (c >= 8'd33 && c <= 8'd47) || (c >= 8'd58 && c <= 8'd64) ||
           (c >= 8'd91 && c <= 8'd96) || (c >= 8'd123 && c <= 8'd126);
  endfunction

endpackage

// File: rtl/ctl_tok_queue.sv
// ----------------------------------------------------------------------------
// ctl_tok_queue
// Three-entry shifting token queue; takes up to two tokens per cycle.
// ----------------------------------------------------------------------------
module ctl_tok_queue (
  input  logic           clk,
  input  logic           rst,
  input  ctl_pkg::push_t push,
  output logic [1:0]     count,
  output logic           tok_valid,
  input  logic           tok_stall,
  output ctl_pkg::tok_t  tok_item
);

  ctl_pkg::tok_t q [3];
  ctl_pkg::tok_t q_next [3];
  logic [1:0]    count_next;
  logic          pop;
  logic [1:0]    base;

  assign tok_valid = (count != 2'd0);
  assign tok_item  = q[0];
  assign pop       = tok_valid && !tok_stall;
  assign base      = count - {1'b0, pop};

  always_comb begin
    q_next[0] = pop ? q[1] : q[0];
    q_next[1] = pop ? q[2] : q[1];
    q_next[2] = q[2];
    for (int i = 0; i < 3; i++) begin
      if (push.n != 2'd0 && 2'(i) == base) q_next[i] = push.a;
      if (push.n == 2'd2 && 2'(i) == base + 2'd1) q_next[i] = push.b;
    end
    count_next = base + push.n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count_next;
    end
    for (int i = 0; i < 3; i++) q[i] <= q_next[i];
  end

`ifndef SYNTHESIS
  a_push_n: assert property (@(posedge clk) disable iff (rst) push.n != 2'd3)
    else $error("more than two tokens pushed");
  a_room: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, base} + {1'b0, push.n}) <= 3'd3)
    else $error("token queue overflow");
  a_last: assert property (@(posedge clk) disable iff (rst)
    push.n == 2'd2 |-> (!push.a.last_of_run && push.b.last_of_run))
    else $error("last_of_run misplaced on a pair");
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd1 && pop && push.n == 2'd0) |=> !tok_valid)
    else $error("queue not empty after last transfer");
`endif

endmodule

// File: rtl/c_token_lexer.sv
// ----------------------------------------------------------------------------
// c_token_lexer
// Byte-serial C lexer: splits a line into words and punctuation tokens and
// classifies each one, with a token limit set over an APB port.
// ----------------------------------------------------------------------------
//  channel  direction  handshake               payload
//  char     in         char_valid/char_stall   ctl_pkg::char_t
//  tok      out        tok_valid/tok_stall     ctl_pkg::tok_t
//  apb      in         psel/penable/pready     max_tokens at byte address 0
//
//  one byte is taken per cycle while char_stall is low; its tokens enter the output queue at once
//  a byte that yields two tokens (word plus punctuation) pushes both in the same cycle
//  rate is set by the three-entry output queue: char_stall rises at two queued
//  reset clears the open word, the column, the token count; limit becomes 200
//  tok_stall only fills the queue; bytes are taken until two tokens wait
// ----------------------------------------------------------------------------
module c_token_lexer #(
  parameter int LINE_COLUMNS = 256
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           char_valid,
  output logic           char_stall,
  input  ctl_pkg::char_t char_item,
  output logic           tok_valid,
  input  logic           tok_stall,
  output ctl_pkg::tok_t  tok_item,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [2:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);

  localparam logic [2:0] RegMaxTokens = 3'd0;
  localparam logic [7:0] LastColumn   = 8'(LINE_COLUMNS - 1);

  logic [15:0] max_tokens;
  logic        word_open,  word_open_next;
  logic [7:0]  word_start, word_start_next;
  logic [7:0]  word_length, word_length_next;
  logic [63:0] word_bytes, word_bytes_next;
  logic [7:0]  column,     column_next;
  logic [15:0] token_count, token_count_next;

  logic [1:0]     q_count;
  ctl_pkg::push_t push;
  ctl_pkg::tok_t  word_tok, punct_tok;
  logic           accept, eol, space, punct, close, word_ok, punct_ok;
  logic [15:0]    count_mid;
  logic [7:0]     len_base;
  logic [63:0]    bytes_base;

  assign pready     = 1'b1;
  assign prdata     = (paddr == RegMaxTokens) ? {16'd0, max_tokens} : 32'd0;
  assign char_stall = (q_count >= 2'd2);
  assign accept     = char_valid && !char_stall;

  assign eol   = char_item.action || (char_item.character == 8'd0);
  assign space = !eol && ctl_pkg::is_space(char_item.character);
  assign punct = !eol && ctl_pkg::is_punct(char_item.character);
  assign close = word_open && (eol || space || punct);

  assign word_ok   = close && (token_count < max_tokens);
  assign count_mid = token_count + {15'd0, word_ok};
  assign punct_ok  = punct && (count_mid < max_tokens);

  always_comb begin
    word_tok.token_class  = ctl_pkg::word_class(word_bytes, word_length);
    word_tok.token_start  = word_start;
    word_tok.token_length = word_length;
    word_tok.token_text   = word_bytes;
    word_tok.token_number = token_count;
    word_tok.last_of_run  = !punct_ok;

    punct_tok.token_class  = ctl_pkg::punct_class(char_item.character);
    punct_tok.token_start  = column;
    punct_tok.token_length = 8'd1;
    punct_tok.token_text   = {56'd0, char_item.character};
    punct_tok.token_number = count_mid;
    punct_tok.last_of_run  = 1'b1;

    push.n = 2'd0;
    push.a = word_tok;
    push.b = punct_tok;
    if (accept) begin
      push.n = {1'b0, word_ok} + {1'b0, punct_ok};
      if (!word_ok) push.a = punct_tok;
    end
  end

  always_comb begin
    word_open_next   = word_open;
    word_start_next  = word_start;
    word_length_next = word_length;
    word_bytes_next  = word_bytes;
    column_next      = column;
    token_count_next = token_count;
    len_base         = word_open ? word_length : 8'd0;
    bytes_base       = word_open ? word_bytes : 64'd0;
    if (accept) begin
      token_count_next = count_mid + {15'd0, punct_ok};
      column_next      = (column == LastColumn) ? 8'd0 : column + 8'd1;
      if (eol) column_next = 8'd0;
      if (eol || space || punct) begin
        word_open_next   = 1'b0;
        word_start_next  = 8'd0;
        word_length_next = 8'd0;
        word_bytes_next  = 64'd0;
      end else begin
        word_open_next = 1'b1;
        if (!word_open) word_start_next = column;
        word_bytes_next = bytes_base;
        if (len_base < 8'(ctl_pkg::TextBytes))
          word_bytes_next[8*len_base[2:0] +: 8] = char_item.character;
        word_length_next = (len_base < ctl_pkg::LengthMax) ? len_base + 8'd1 : len_base;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_tokens  <= ctl_pkg::TokenLimitReset;
      word_open   <= 1'b0;
      word_start  <= 8'd0;
      word_length <= 8'd0;
      word_bytes  <= 64'd0;
      column      <= 8'd0;
      token_count <= 16'd0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == RegMaxTokens)
        max_tokens <= pwdata[15:0];
      word_open   <= word_open_next;
      word_start  <= word_start_next;
      word_length <= word_length_next;
      word_bytes  <= word_bytes_next;
      column      <= column_next;
      token_count <= token_count_next;
    end
  end

  ctl_tok_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .count     (q_count),
    .tok_valid (tok_valid),
    .tok_stall (tok_stall),
    .tok_item  (tok_item)
  );

endmodule
